@@ hdl/fspa_pkg.sv @@
package fspa_pkg;

    // fixed field widths
    localparam int OFF_W      = 14;
    localparam int NUM_W      = 8;
    localparam int USED_W     = 9;
    localparam int STATUS_W   = 2;
    localparam int SB_W       = 13;
    localparam int SPB_W      = 7;
    localparam int NB_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 40;

    // register reset values
    localparam logic [SB_W-1:0]  SLOT_BYTES_RST      = 13'd16;
    localparam logic [SPB_W-1:0] SLOTS_PER_BLOCK_RST = 7'd64;
    localparam logic [NB_W-1:0]  BLOCKS_IN_USE_RST   = 3'd4;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLOT_BYTES      = 2'd0,
        CFG_SLOTS_PER_BLOCK = 2'd1,
        CFG_BLOCKS_IN_USE   = 2'd2
    } t_cfg_index;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_FREE  = 2'd3
    } t_status;

    // request kinds
    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } t_req;

    // controller states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_A_READ,
        S_A_CHECK,
        S_F_DIV1,
        S_F_DIV2,
        S_F_READ,
        S_F_UPD,
        S_MUL,
        S_DONE
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        logic    clr;
        logic    rd;
        logic    blk_inc;
        logic    alloc_set;
        logic    div_step;
        logic    div_slot;
        logic    free_latch;
        logic    free_upd;
        logic    mul;
        logic    out_load;
        t_status out_status;
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic blk_last;
        logic blk_ge_nb;
        logic slot_found;
        logic div_done;
        logic range_bad;
        logic bit_set;
        logic out_busy;
    } t_dp_stat;

endpackage

@@ hdl/fixed_slot_pool_allocator_core.sv @@
// Fixed-size slot allocator over a chain of equal blocks. An allocate request
// scans blocks in order, each block looked at by a row read, then a check
// of the block's count and a first-free search of its used bits; its result
// is loaded into the output register once a block with a free slot is found
// or the blocks in use run out (a full pool looks at every block in use). A
// free request finds its block by comparing the offset against the block
// boundaries, then divides the offset within the block by the slot size with a
// serial divider that yields one quotient bit per cycle (14 steps): its result
// is loaded after the row update, or straight after the divide for an offset
// outside the pool. The next request is taken in the cycle after a result is
// loaded, and a result that is ready stalls while the output register still
// holds one not yet taken. After reset the used rows are cleared one row per
// cycle, all MAX_BLOCKS of them, with no request taken (configuration writes
// are taken). Errors (pool full, offset outside the pool, slot already free)
// report a status and change nothing.
module fixed_slot_pool_allocator_core #(
    parameter int BLOCK_BYTES         = 4096,
    parameter int MAX_BLOCKS          = 4,
    parameter int MAX_SLOTS_PER_BLOCK = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fspa_pkg::S_DATA_W-1:0]   s_axis_tdata,   // free_offset[13:0], zero pad
    input  logic                            s_axis_tuser,   // req_type
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fspa_pkg::M_DATA_W-1:0]   m_axis_tdata,   // slot_offset[13:0],
                                                            // slot_number[21:14],
                                                            // used_slots[30:22],
                                                            // total_slots[39:31]
    output logic [fspa_pkg::STATUS_W-1:0]   m_axis_tuser,   // status
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fspa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fspa_pkg::*;

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [OFF_W-1:0]   w_slot_offset;
    logic [NUM_W-1:0]   w_slot_number;
    logic [USED_W-1:0]  w_used_slots;
    logic [USED_W-1:0]  w_total_slots;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    // sequencer
    fspa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // storage, divider and result registers
    fspa_dp #(
        .BLOCK_BYTES         (BLOCK_BYTES),
        .MAX_BLOCKS          (MAX_BLOCKS),
        .MAX_SLOTS_PER_BLOCK (MAX_SLOTS_PER_BLOCK)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_free_offset (s_axis_tdata[OFF_W-1:0]),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_slot_offset (w_slot_offset),
        .o_slot_number (w_slot_number),
        .o_status      (m_axis_tuser),
        .o_used_slots  (w_used_slots),
        .o_total_slots (w_total_slots)
    );

    // result packing
    assign m_axis_tdata = {w_total_slots, w_used_slots, w_slot_number, w_slot_offset};

endmodule

@@ hdl/fspa_dp.sv @@
module fspa_dp #(
    parameter int BLOCK_BYTES         = 4096,
    parameter int MAX_BLOCKS          = 4,
    parameter int MAX_SLOTS_PER_BLOCK = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fspa_pkg::t_dp_cmd                   i_cmd,
    output fspa_pkg::t_dp_stat                  o_stat,
    input  logic                                i_cfg_valid,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fspa_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [fspa_pkg::OFF_W-1:0]          i_free_offset,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [fspa_pkg::OFF_W-1:0]          o_slot_offset,
    output logic [fspa_pkg::NUM_W-1:0]          o_slot_number,
    output logic [fspa_pkg::STATUS_W-1:0]       o_status,
    output logic [fspa_pkg::USED_W-1:0]         o_used_slots,
    output logic [fspa_pkg::USED_W-1:0]         o_total_slots
);
    import fspa_pkg::*;

    localparam int BLK_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int BKC_W = $clog2(MAX_BLOCKS + 1);
    localparam int SLT_W = (MAX_SLOTS_PER_BLOCK > 1) ? $clog2(MAX_SLOTS_PER_BLOCK) : 1;
    localparam int CNT_W = $clog2(MAX_SLOTS_PER_BLOCK + 1);
    localparam int SCW   = (SLT_W + 1 > SPB_W) ? SLT_W + 1 : SPB_W;
    localparam int NBW   = (BKC_W > NB_W) ? BKC_W : NB_W;
    localparam int ROW_W = MAX_SLOTS_PER_BLOCK + CNT_W;
    localparam int DVS_W = SB_W;
    localparam int CMP_W = (OFF_W + 1 > DVS_W) ? OFF_W + 1 : DVS_W;
    localparam int DCN_W = $clog2(OFF_W + 1);
    localparam int PRD_W = SLT_W + SB_W;

    // configuration registers
    logic [SB_W-1:0]  r_slot_bytes;
    logic [SPB_W-1:0] r_slots_per_block;
    logic [NB_W-1:0]  r_blocks_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_bytes      <= SLOT_BYTES_RST;
            r_slots_per_block <= SLOTS_PER_BLOCK_RST;
            r_blocks_in_use   <= BLOCKS_IN_USE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SLOT_BYTES:      r_slot_bytes      <= i_cfg_data[SB_W-1:0];
                CFG_SLOTS_PER_BLOCK: r_slots_per_block <= i_cfg_data[SPB_W-1:0];
                CFG_BLOCKS_IN_USE:   r_blocks_in_use   <= i_cfg_data[NB_W-1:0];
                default: ;
            endcase
        end
    end

    // effective geometry after clamping
    logic [SB_W-1:0]      w_eff_sb;
    logic [SCW-1:0]       w_eff_spb;
    logic [NBW-1:0]       w_eff_nb;
    logic [SCW+NBW-1:0]   w_total;

    always_comb begin
        w_eff_sb  = (r_slot_bytes == '0) ? SB_W'(1) : r_slot_bytes;
        w_eff_spb = (SCW'(r_slots_per_block) > SCW'(MAX_SLOTS_PER_BLOCK))
                    ? SCW'(MAX_SLOTS_PER_BLOCK) : SCW'(r_slots_per_block);
        w_eff_nb  = (NBW'(r_blocks_in_use) > NBW'(MAX_BLOCKS))
                    ? NBW'(MAX_BLOCKS) : NBW'(r_blocks_in_use);
        w_total   = (SCW+NBW)'(w_eff_spb) * (SCW+NBW)'(w_eff_nb);
    end

    // block pointer, request offset, pool count
    logic [BKC_W-1:0]  r_blk;
    logic [SLT_W-1:0]  r_slot;
    logic [OFF_W-1:0]  r_off;
    logic [USED_W-1:0] r_pool;

    // row memory: used bits in the low part, slots-in-use count on top
    logic [ROW_W-1:0]  r_mem [MAX_BLOCKS];
    logic [ROW_W-1:0]  r_row;
    logic [BLK_W-1:0]  w_addr;
    logic              w_we;
    logic [ROW_W-1:0]  w_wdata;

    logic [MAX_SLOTS_PER_BLOCK-1:0] w_bits;
    logic [CNT_W-1:0]               w_cnt;
    logic                           w_any_free;
    logic [SLT_W-1:0]               w_free_idx;
    logic                           w_cnt_ok;
    logic                           w_bit_set;
    logic [SLT_W-1:0]               w_sel_slot;
    logic [MAX_SLOTS_PER_BLOCK-1:0] w_onehot;

    assign w_addr = r_blk[BLK_W-1:0];
    assign w_bits = r_row[MAX_SLOTS_PER_BLOCK-1:0];
    assign w_cnt  = r_row[ROW_W-1:MAX_SLOTS_PER_BLOCK];

    // first free slot below the effective slot count
    always_comb begin
        w_any_free = 1'b0;
        w_free_idx = '0;
        for (int i = MAX_SLOTS_PER_BLOCK - 1; i >= 0; i--) begin
            if ((SCW'(i) < w_eff_spb) && !w_bits[i]) begin
                w_any_free = 1'b1;
                w_free_idx = SLT_W'(i);
            end
        end
    end

    assign w_cnt_ok   = SCW'(w_cnt) < w_eff_spb;
    assign w_bit_set  = w_bits[r_slot];
    assign w_sel_slot = i_cmd.alloc_set ? w_free_idx : r_slot;
    assign w_onehot   = MAX_SLOTS_PER_BLOCK'(1) << w_sel_slot;

    // row write: clear pass, allocate set, free clear
    always_comb begin
        w_we    = 1'b0;
        w_wdata = '0;
        if (i_cmd.clr) begin
            w_we    = 1'b1;
            w_wdata = '0;
        end else if (i_cmd.alloc_set) begin
            w_we    = 1'b1;
            w_wdata = {w_cnt + CNT_W'(1), w_bits | w_onehot};
        end else if (i_cmd.free_upd && w_bit_set) begin
            w_we    = 1'b1;
            w_wdata = {(w_cnt != '0) ? w_cnt - CNT_W'(1) : w_cnt, w_bits & ~w_onehot};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (i_cmd.rd) begin
            r_row <= r_mem[w_addr];
        end
    end

    // block number and offset within the block by comparing to block boundaries
    logic [BKC_W-1:0] w_blk_q;
    logic [OFF_W-1:0] w_within;

    always_comb begin
        w_blk_q  = '0;
        w_within = r_off;
        for (int k = 1; k <= MAX_BLOCKS; k++) begin
            if (32'(r_off) >= 32'(k * BLOCK_BYTES)) begin
                w_blk_q  = BKC_W'(k);
                w_within = OFF_W'(32'(r_off) - 32'(k * BLOCK_BYTES));
            end
        end
    end

    // serial restoring divider by the slot size, one quotient bit per cycle
    logic [OFF_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [OFF_W-1:0] r_rem;
    logic [OFF_W-1:0] r_quo;
    logic [OFF_W-1:0] r_bq;
    logic [DCN_W-1:0] r_dcnt;
    logic [OFF_W:0]   w_trial;
    logic             w_ge;
    logic [CMP_W-1:0] w_diff;

    assign w_trial = {r_rem, r_dvd[OFF_W-1]};
    assign w_ge    = CMP_W'(w_trial) >= CMP_W'(r_dvs);
    assign w_diff  = CMP_W'(w_trial) - CMP_W'(r_dvs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_slot) begin
            r_bq   <= OFF_W'(w_blk_q);
            r_dvd  <= w_within;
            r_dvs  <= w_eff_sb;
            r_rem  <= '0;
            r_dcnt <= DCN_W'(OFF_W);
        end else if (i_cmd.div_step) begin
            r_rem  <= w_ge ? w_diff[OFF_W-1:0] : w_trial[OFF_W-1:0];
            r_quo  <= {r_quo[OFF_W-2:0], w_ge};
            r_dvd  <= {r_dvd[OFF_W-2:0], 1'b0};
            r_dcnt <= r_dcnt - DCN_W'(1);
        end
    end

    // block pointer and slot register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blk <= '0;
        end else if (i_cmd.load) begin
            r_blk <= '0;
        end else if (i_cmd.clr || i_cmd.blk_inc) begin
            r_blk <= r_blk + BKC_W'(1);
        end else if (i_cmd.free_latch) begin
            r_blk <= r_bq[BKC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_off <= i_free_offset;
        end
        if (i_cmd.alloc_set) begin
            r_slot <= w_free_idx;
        end else if (i_cmd.free_latch) begin
            r_slot <= r_quo[SLT_W-1:0];
        end
    end

    // pool-wide slots in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= '0;
        end else if (i_cmd.alloc_set) begin
            r_pool <= r_pool + USED_W'(1);
        end else if (i_cmd.free_upd && w_bit_set && (r_pool != '0)) begin
            r_pool <= r_pool - USED_W'(1);
        end
    end

    // offset and slot number products
    logic [OFF_W-1:0] r_prod;
    logic [OFF_W-1:0] r_base;
    logic [NUM_W-1:0] r_num;
    logic [PRD_W-1:0] w_prod;

    assign w_prod = PRD_W'(r_slot) * PRD_W'(w_eff_sb);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= w_prod[OFF_W-1:0];
            r_base <= OFF_W'(r_blk * BLOCK_BYTES);
            r_num  <= NUM_W'(r_blk * MAX_SLOTS_PER_BLOCK + r_slot);
        end
    end

    // output register
    logic                r_out_valid;
    logic [OFF_W-1:0]    r_out_offset;
    logic [NUM_W-1:0]    r_out_number;
    t_status             r_out_status;
    logic [USED_W-1:0]   r_out_used;
    logic [USED_W-1:0]   r_out_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= i_cmd.out_status;
            r_out_used   <= r_pool;
            r_out_total  <= w_total[USED_W-1:0];
            case (i_cmd.out_status)
                ST_FULL: begin
                    r_out_offset <= '0;
                    r_out_number <= '0;
                end
                ST_RANGE: begin
                    r_out_offset <= r_off;
                    r_out_number <= '0;
                end
                default: begin
                    r_out_offset <= r_base + r_prod;
                    r_out_number <= r_num;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot_offset = r_out_offset;
    assign o_slot_number = r_out_number;
    assign o_status      = r_out_status;
    assign o_used_slots  = r_out_used;
    assign o_total_slots = r_out_total;

    // status to controller
    always_comb begin
        o_stat.blk_last   = r_blk == BKC_W'(MAX_BLOCKS - 1);
        o_stat.blk_ge_nb  = NBW'(r_blk) >= w_eff_nb;
        o_stat.slot_found = w_cnt_ok && w_any_free;
        o_stat.div_done   = r_dcnt == '0;
        o_stat.range_bad  = (r_bq >= OFF_W'(w_eff_nb)) || (r_quo >= OFF_W'(w_eff_spb));
        o_stat.bit_set    = w_bit_set;
        o_stat.out_busy   = r_out_valid && !i_out_ready;
    end

endmodule

@@ hdl/fspa_ctrl.sv @@
module fspa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    output logic               o_in_ready,
    input  fspa_pkg::t_dp_stat i_stat,
    output fspa_pkg::t_dp_cmd  o_cmd
);
    import fspa_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_status;
    t_status n_status;

    // state and result status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_status <= ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

    // next state and commands
    always_comb begin
        n_state          = r_state;
        n_status         = r_status;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.out_status = r_status;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.blk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_req_type == REQ_FREE) ? S_F_DIV1 : S_A_READ;
                end
            end
            S_A_READ: begin
                if (i_stat.blk_ge_nb) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_A_CHECK;
                end
            end
            S_A_CHECK: begin
                if (i_stat.slot_found) begin
                    o_cmd.alloc_set = 1'b1;
                    n_status        = ST_OK;
                    n_state         = S_MUL;
                end else begin
                    o_cmd.blk_inc = 1'b1;
                    n_state       = S_A_READ;
                end
            end
            S_F_DIV1: begin
                o_cmd.div_slot = 1'b1;
                n_state        = S_F_DIV2;
            end
            S_F_DIV2: begin
                if (!i_stat.div_done) begin
                    o_cmd.div_step = 1'b1;
                end else if (i_stat.range_bad) begin
                    n_status = ST_RANGE;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.free_latch = 1'b1;
                    n_state          = S_F_READ;
                end
            end
            S_F_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_F_UPD;
            end
            S_F_UPD: begin
                o_cmd.free_upd = 1'b1;
                n_status       = i_stat.bit_set ? ST_OK : ST_FREE;
                n_state        = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
